FILE: hdl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

	// default geometry of the arena
	localparam int ARENA_BYTES_DEF  = 4096;
	localparam int HEADER_BYTES_DEF = 12;

	// field widths of the request and response
	localparam int OPCODE_W = 1;
	localparam int REQ_W    = 13;
	localparam int OFF_W    = 12;
	localparam int STATUS_W = 2;
	localparam int SDATA_W  = 32;
	localparam int MDATA_W  = 16;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

	// walk pointer update
	typedef enum logic [2:0] {
		H_HOLD,
		H_ZERO,
		H_NEXT,
		H_NBR,
		H_DOFF
	} h_op_t;

	// header read select
	typedef enum logic [1:0] {
		RD_NONE,
		RD_CUR,
		RD_NBR
	} rd_op_t;

	// header write select
	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_SPLIT,
		WR_ALLOC,
		WR_FREE,
		WR_MERGE,
		WR_KILL
	} wr_op_t;

	// controller to datapath
	typedef struct packed {
		logic                load_in;
		h_op_t               h_op;
		rd_op_t              rd_op;
		wr_op_t              wr_op;
		logic                save_nbr;
		logic                out_load;
		logic [STATUS_W-1:0] out_status;
		logic                out_with_offset;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic h_out;
		logic n_out;
		logic fit;
		logic split;
		logic rd_start;
		logic rd_free;
		logic doff_bad;
		logic clr_last;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/ffa_dpath.sv
`default_nettype none
module ffa_dpath #(
	parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  ffa_pkg::cmd_t               cmd,
	output ffa_pkg::dp_status_t         st,
	input  wire  [ffa_pkg::SDATA_W-1:0] s_tdata,
	output logic [ffa_pkg::MDATA_W-1:0] m_tdata,
	output logic [ffa_pkg::STATUS_W-1:0] m_tuser
);
	import ffa_pkg::*;

	localparam int AW = $clog2(ARENA_BYTES);
	localparam int HW = AW + 1;
	localparam int CW = ((AW > REQ_W) ? AW : REQ_W) + 2;
	localparam int DW = ((AW > OFF_W) ? AW : OFF_W) + 1;

	typedef struct packed {
		logic          start;
		logic          is_free;
		logic [AW-1:0] size;
	} hdr_t;

	// header store, one entry per byte offset
	hdr_t mem [ARENA_BYTES];
	hdr_t rd_q;

	logic [HW-1:0]    h_q;
	logic [HW-1:0]    n_q;
	logic [AW-1:0]    size_q;
	logic [REQ_W-1:0] req_q;
	logic [OFF_W-1:0] doff_q;
	logic [AW-1:0]    clr_q;

	logic [HW-1:0] next_h;
	logic [DW-1:0] doff_h;
	logic          split;
	logic          we;
	logic [AW-1:0] wa;
	hdr_t          wd;
	logic          re;
	logic [AW-1:0] ra;

	// block arithmetic
	assign next_h = h_q + HW'(HEADER_BYTES) + HW'(rd_q.size);
	assign doff_h = DW'(doff_q) - DW'(HEADER_BYTES);
	assign split  = CW'(rd_q.size) > (CW'(req_q) + CW'(HEADER_BYTES));

	// status toward the controller
	assign st.h_out    = h_q >= HW'(ARENA_BYTES);
	assign st.n_out    = next_h >= HW'(ARENA_BYTES);
	assign st.fit      = rd_q.is_free && (CW'(rd_q.size) >= CW'(req_q));
	assign st.split    = split;
	assign st.rd_start = rd_q.start;
	assign st.rd_free  = rd_q.is_free;
	assign st.doff_bad = (DW'(doff_q) < DW'(HEADER_BYTES)) || (doff_h >= DW'(ARENA_BYTES));
	assign st.clr_last = clr_q == AW'(ARENA_BYTES - 1);

	// write port select
	always_comb begin
		we = 1'b1;
		wa = AW'(h_q);
		wd = '0;
		case (cmd.wr_op)
			WR_CLEAR: begin
				wa = clr_q;
				if (clr_q == '0) begin
					wd.start   = 1'b1;
					wd.is_free = 1'b1;
					wd.size    = AW'(ARENA_BYTES - HEADER_BYTES);
				end
			end
			WR_SPLIT: begin
				wa         = AW'(h_q + HW'(HEADER_BYTES) + HW'(req_q));
				wd.start   = 1'b1;
				wd.is_free = 1'b1;
				wd.size    = AW'(CW'(rd_q.size) - CW'(req_q) - CW'(HEADER_BYTES));
			end
			WR_ALLOC: begin
				wd.start   = 1'b1;
				wd.is_free = 1'b0;
				wd.size    = split ? AW'(req_q) : rd_q.size;
			end
			WR_FREE: begin
				wd.start   = 1'b1;
				wd.is_free = 1'b1;
				wd.size    = rd_q.size;
			end
			WR_MERGE: begin
				wd.start   = 1'b1;
				wd.is_free = 1'b1;
				wd.size    = size_q + AW'(HEADER_BYTES) + rd_q.size;
			end
			WR_KILL: begin
				wa = AW'(n_q);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// read port select
	always_comb begin
		re = 1'b1;
		ra = AW'(h_q);
		case (cmd.rd_op)
			RD_CUR:  ra = AW'(h_q);
			RD_NBR:  ra = AW'(next_h);
			default: re = 1'b0;
		endcase
	end

	// header memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	// clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.wr_op == WR_CLEAR && clr_q != AW'(ARENA_BYTES - 1)) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// request fields, walk pointer and neighbor
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q  <= s_tdata[REQ_W-1:0];
			doff_q <= s_tdata[REQ_W+OFF_W-1:REQ_W];
		end
		case (cmd.h_op)
			H_ZERO:  h_q <= '0;
			H_NEXT:  h_q <= next_h;
			H_NBR:   h_q <= n_q;
			H_DOFF:  h_q <= HW'(doff_h);
			default: h_q <= h_q;
		endcase
		if (cmd.save_nbr) begin
			n_q    <= next_h;
			size_q <= rd_q.size;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tuser <= cmd.out_status;
			if (cmd.out_with_offset) begin
				m_tdata <= MDATA_W'(OFF_W'(h_q + HW'(HEADER_BYTES)));
			end else begin
				m_tdata <= '0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [ffa_pkg::OPCODE_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	input  ffa_pkg::dp_status_t           st,
	output ffa_pkg::cmd_t                 cmd
);
	import ffa_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_RD,
		S_A_EV,
		S_A_SPLIT,
		S_F_CHK,
		S_F_RD,
		S_F_EV,
		S_M_RD,
		S_M_EV,
		S_M_EV2,
		S_M_KILL,
		S_RESP
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] pend_status_q;
	logic                pend_off_q;
	logic                out_free;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	// sequencer state and response bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			out_valid_q   <= 1'b0;
			pend_status_q <= ST_DONE;
			pend_off_q    <= 1'b0;
		end else begin
			// response valid: raised when a response is loaded, dropped once taken
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (st.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= (s_tuser == OP_ALLOC) ? S_A_RD : S_F_CHK;
					end
				end
				S_A_RD: begin
					if (st.h_out) begin
						pend_status_q <= ST_NO_FIT;
						pend_off_q    <= 1'b0;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_A_EV;
					end
				end
				S_A_EV: begin
					if (st.fit) begin
						if (st.split) begin
							state_q <= S_A_SPLIT;
						end else begin
							pend_status_q <= ST_DONE;
							pend_off_q    <= 1'b1;
							state_q       <= S_RESP;
						end
					end else begin
						state_q <= S_A_RD;
					end
				end
				S_A_SPLIT: begin
					pend_status_q <= ST_DONE;
					pend_off_q    <= 1'b1;
					state_q       <= S_RESP;
				end
				S_F_CHK: begin
					if (st.doff_bad) begin
						pend_status_q <= ST_IGNORED;
						pend_off_q    <= 1'b0;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_F_RD: begin
					state_q <= S_F_EV;
				end
				S_F_EV: begin
					if (!st.rd_start) begin
						pend_status_q <= ST_IGNORED;
						pend_off_q    <= 1'b0;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_M_RD;
					end
				end
				S_M_RD: begin
					if (st.h_out) begin
						pend_status_q <= ST_DONE;
						pend_off_q    <= 1'b0;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_M_EV;
					end
				end
				S_M_EV: begin
					if (!st.rd_free) begin
						state_q <= S_M_RD;
					end else if (st.n_out) begin
						pend_status_q <= ST_DONE;
						pend_off_q    <= 1'b0;
						state_q       <= S_RESP;
					end else begin
						state_q <= S_M_EV2;
					end
				end
				S_M_EV2: begin
					state_q <= st.rd_free ? S_M_KILL : S_M_RD;
				end
				S_M_KILL: begin
					state_q <= S_M_RD;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd                 = '0;
		cmd.h_op            = H_HOLD;
		cmd.rd_op           = RD_NONE;
		cmd.wr_op           = WR_NONE;
		cmd.out_status      = pend_status_q;
		cmd.out_with_offset = pend_off_q;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_op = WR_CLEAR;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					cmd.h_op    = H_ZERO;
				end
			end
			S_A_RD: begin
				if (!st.h_out) begin
					cmd.rd_op = RD_CUR;
				end
			end
			S_A_EV: begin
				if (st.fit) begin
					cmd.wr_op = st.split ? WR_SPLIT : WR_ALLOC;
				end else begin
					cmd.h_op = H_NEXT;
				end
			end
			S_A_SPLIT: begin
				cmd.wr_op = WR_ALLOC;
			end
			S_F_CHK: begin
				if (!st.doff_bad) begin
					cmd.h_op = H_DOFF;
				end
			end
			S_F_RD: begin
				cmd.rd_op = RD_CUR;
			end
			S_F_EV: begin
				if (st.rd_start) begin
					cmd.wr_op = WR_FREE;
					cmd.h_op  = H_ZERO;
				end
			end
			S_M_RD: begin
				if (!st.h_out) begin
					cmd.rd_op = RD_CUR;
				end
			end
			S_M_EV: begin
				if (!st.rd_free) begin
					cmd.h_op = H_NEXT;
				end else if (!st.n_out) begin
					cmd.save_nbr = 1'b1;
					cmd.rd_op    = RD_NBR;
				end
			end
			S_M_EV2: begin
				if (st.rd_free) begin
					cmd.wr_op = WR_MERGE;
				end else begin
					cmd.h_op = H_NBR;
				end
			end
			S_M_KILL: begin
				cmd.wr_op = WR_KILL;
			end
			S_RESP: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd.load_in = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/first_fit_heap_allocator_core.sv
// allocate walks the headers from offset 0, reading and checking each; a split adds a tail header write
// free checks the offset, reads and frees its header, then walks the chain from offset 0 and merges
// each free block with a free neighbor; a bad offset or a header that is not a block start is ignored
// one request at a time; the header memory's single read port sets the walk rate
// a response waits in the output register while the next request is taken
// reset: a clearing sweep over every byte offset rebuilds the header memory, no request taken
`default_nettype none
module first_fit_heap_allocator_core #(
	parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// request channel
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire  [ffa_pkg::SDATA_W-1:0]   s_axis_tdata,  // req_size[12:0], data_offset[24:13]
	input  wire  [ffa_pkg::OPCODE_W-1:0]  s_axis_tuser,  // opcode[0]
	// response channel
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	output logic [ffa_pkg::MDATA_W-1:0]   m_axis_tdata,  // alloc_offset[11:0]
	output logic [ffa_pkg::STATUS_W-1:0]  m_axis_tuser   // status[1:0]
);
	import ffa_pkg::*;

	cmd_t       cmd;
	dp_status_t st;

	// sequencer
	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tuser  (s_axis_tuser),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// header memory and block arithmetic
	ffa_dpath #(
		.ARENA_BYTES  (ARENA_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.st      (st),
		.s_tdata (s_axis_tdata),
		.m_tdata (m_axis_tdata),
		.m_tuser (m_axis_tuser)
	);

endmodule
`default_nettype wire

FILE: bench/first_fit_heap_allocator_core_tb.sv
`default_nettype none
module first_fit_heap_allocator_core_tb;
	import ffa_pkg::*;

	localparam int ARENA         = ARENA_BYTES_DEF;
	localparam int HDR           = HEADER_BYTES_DEF;
	localparam int N_DIRECTED    = 24;
	localparam int N_PHASES      = 5;
	localparam int PHASE_ITEMS   = 125;
	localparam int PRESSURE_PH   = 4;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 20000;
	localparam int DRAIN_CYCLES  = 100;
	localparam int LIVE_TARGET   = 24;
	localparam int RELEASED_KEEP = 16;

	// idle percentages of the request and response sides per phase
	localparam int SEND_IDLE [N_PHASES]  = '{0, 68, 0, 23, 0};
	localparam int RECV_STALL [N_PHASES] = '{0, 0, 68, 23, 0};

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFF_W-1:0]    offset;
	} heap_resp_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic [REQ_W-1:0]    size;
		logic [OFF_W-1:0]    doff;
		logic                fixed;
		heap_resp_t          resp;
	} directed_row_t;

	// directed requests; fixed rows carry their response, others use the heap image
	localparam directed_row_t DIRECTED [N_DIRECTED] = '{
		'{OP_ALLOC, 13'd4096, 12'd0,    1'b1, '{ST_NO_FIT, 12'd0}},
		'{OP_FREE,  13'd0,    12'd0,    1'b1, '{ST_IGNORED, 12'd0}},
		'{OP_FREE,  13'd0,    12'd5,    1'b1, '{ST_IGNORED, 12'd0}},
		'{OP_FREE,  13'd8191, 12'd4095, 1'b1, '{ST_IGNORED, 12'd0}},
		'{OP_ALLOC, 13'd0,    12'd0,    1'b1, '{ST_DONE, 12'd12}},
		'{OP_ALLOC, 13'd100,  12'd0,    1'b1, '{ST_DONE, 12'd24}},
		'{OP_ALLOC, 13'd4084, 12'd0,    1'b1, '{ST_NO_FIT, 12'd0}},
		'{OP_FREE,  13'd0,    12'd12,   1'b1, '{ST_DONE, 12'd0}},
		'{OP_FREE,  13'd0,    12'd12,   1'b1, '{ST_DONE, 12'd0}},
		'{OP_ALLOC, 13'd0,    12'd0,    1'b1, '{ST_DONE, 12'd12}},
		'{OP_FREE,  13'd0,    12'd24,   1'b1, '{ST_DONE, 12'd0}},
		'{OP_FREE,  13'd0,    12'd12,   1'b1, '{ST_DONE, 12'd0}},
		'{OP_ALLOC, 13'd4084, 12'd0,    1'b1, '{ST_DONE, 12'd12}},
		'{OP_ALLOC, 13'd0,    12'd0,    1'b1, '{ST_NO_FIT, 12'd0}},
		'{OP_FREE,  13'd0,    12'd12,   1'b1, '{ST_DONE, 12'd0}},
		'{OP_ALLOC, 13'd4072, 12'd0,    1'b1, '{ST_DONE, 12'd12}},
		'{OP_FREE,  13'd0,    12'd12,   1'b1, '{ST_DONE, 12'd0}},
		'{OP_ALLOC, 13'd4071, 12'd0,    1'b1, '{ST_DONE, 12'd12}},
		'{OP_ALLOC, 13'd1,    12'd0,    1'b1, '{ST_DONE, 12'd4095}},
		'{OP_ALLOC, 13'd0,    12'd0,    1'b1, '{ST_NO_FIT, 12'd0}},
		'{OP_FREE,  13'd0,    12'd4095, 1'b1, '{ST_DONE, 12'd0}},
		'{OP_FREE,  13'd0,    12'd12,   1'b1, '{ST_DONE, 12'd0}},
		'{OP_ALLOC, 13'd2000, 12'd0,    1'b0, '{ST_DONE, 12'd0}},
		'{OP_FREE,  13'd0,    12'd12,   1'b0, '{ST_DONE, 12'd0}}
	};

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	wire                 s_axis_tready;
	logic [SDATA_W-1:0]  s_axis_tdata  = '0;
	logic [OPCODE_W-1:0] s_axis_tuser  = '0;
	wire                 m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	wire  [MDATA_W-1:0]  m_axis_tdata;
	wire  [STATUS_W-1:0] m_axis_tuser;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit pressure_on    = 1'b0;
	int hold_count     = 0;
	int idle_cycles    = 0;
	int errors         = 0;

	// heap image: block start marks, free marks and data sizes per byte offset
	bit               blk_start [ARENA];
	bit               blk_free  [ARENA];
	logic [REQ_W-1:0] blk_size  [ARENA];

	heap_resp_t       resp_due [$];
	logic [OFF_W-1:0] live_blocks [$];
	logic [OFF_W-1:0] released [$];

	first_fit_heap_allocator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void heap_reset();
		for (int i = 0; i < ARENA; i++) begin
			blk_start[i] = 1'b0;
			blk_free[i]  = 1'b0;
			blk_size[i]  = '0;
		end
		blk_start[0] = 1'b1;
		blk_free[0]  = 1'b1;
		blk_size[0]  = REQ_W'(ARENA - HDR);
	endfunction

	function automatic int unsigned block_after(int unsigned h);
		return h + HDR + blk_size[h];
	endfunction

	// one pass over the chain joining every run of adjacent free blocks
	function automatic void coalesce_free();
		int unsigned h;
		int unsigned n;
		h = 0;
		while (h < ARENA) begin
			n = block_after(h);
			if (blk_free[h] && n < ARENA && blk_free[n]) begin
				blk_size[h]  = REQ_W'(blk_size[h] + HDR + blk_size[n]);
				blk_start[n] = 1'b0;
				blk_free[n]  = 1'b0;
				blk_size[n]  = '0;
			end else begin
				h = n;
			end
		end
	endfunction

	// applies one request to the heap image and returns its response
	function automatic heap_resp_t heap_step(logic [OPCODE_W-1:0] op, logic [REQ_W-1:0] size,
		logic [OFF_W-1:0] doff);
		heap_resp_t  r;
		int unsigned h;
		int unsigned bsz;
		int unsigned want;
		int unsigned nb;
		r.status = ST_DONE;
		r.offset = '0;
		want     = size;
		if (op == OP_ALLOC) begin
			r.status = ST_NO_FIT;
			h = 0;
			while (h < ARENA) begin
				bsz = blk_size[h];
				if (blk_free[h] && bsz >= want) begin
					// split off the tail when more than a header is left over
					if (bsz > want + HDR) begin
						nb = h + HDR + want;
						if (nb < ARENA) begin
							blk_start[nb] = 1'b1;
							blk_free[nb]  = 1'b1;
							blk_size[nb]  = REQ_W'(bsz - want - HDR);
						end
						blk_size[h] = REQ_W'(want);
					end
					blk_free[h] = 1'b0;
					r.status    = ST_DONE;
					r.offset    = OFF_W'(h + HDR);
					break;
				end
				h = block_after(h);
			end
		end else if (doff < HDR) begin
			r.status = ST_IGNORED;
		end else begin
			h = doff - HDR;
			if (!blk_start[h]) begin
				r.status = ST_IGNORED;
			end else begin
				blk_free[h] = 1'b1;
				coalesce_free();
			end
		end
		return r;
	endfunction

	// offer one request, wait for it to be taken, then record its response
	task automatic send_request(logic [OPCODE_W-1:0] op, logic [REQ_W-1:0] size,
		logic [OFF_W-1:0] doff, logic fixed, heap_resp_t fixed_resp);
		heap_resp_t predicted;
		int         idx;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= SDATA_W'({doff, size});
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		predicted = heap_step(op, size, doff);
		resp_due.push_back(fixed ? fixed_resp : predicted);
		// keep the list of blocks held by the requester up to date
		if (op == OP_ALLOC && predicted.status == ST_DONE) begin
			live_blocks.push_back(predicted.offset);
		end else if (op == OP_FREE && predicted.status == ST_DONE) begin
			idx = -1;
			foreach (live_blocks[i]) if (live_blocks[i] == doff) idx = i;
			if (idx >= 0) live_blocks.delete(idx);
			released.push_back(doff);
			if (released.size() > RELEASED_KEEP) void'(released.pop_front());
		end
	endtask

	// mostly allocate/free traffic on held blocks, some stray and null frees
	task automatic pick_request(output logic [OPCODE_W-1:0] op, output logic [REQ_W-1:0] size,
		output logic [OFF_W-1:0] doff);
		int unsigned roll;
		int unsigned band;
		roll = $urandom_range(99);
		op   = OP_ALLOC;
		size = REQ_W'($urandom_range(4096));
		doff = OFF_W'($urandom_range(4095));
		if (roll < 10) begin
			case ($urandom_range(3))
				0: begin
					op   = OP_FREE;
					doff = '0;
				end
				1: begin
					op = OP_FREE;
				end
				2: begin
					op = OP_FREE;
					if (released.size() != 0)
						doff = released[$urandom_range(released.size() - 1)];
				end
				default: begin
					op = OP_ALLOC;
				end
			endcase
		end else if (live_blocks.size() == 0 || (live_blocks.size() < LIVE_TARGET && roll < 55)) begin
			band = $urandom_range(99);
			if (band < 10)
				size = '0;
			else if (band < 80)
				size = REQ_W'($urandom_range(160, 1));
			else if (band < 95)
				size = REQ_W'($urandom_range(1000, 161));
			else
				size = REQ_W'($urandom_range(4096, 1000));
		end else begin
			op   = OP_FREE;
			doff = live_blocks[$urandom_range(live_blocks.size() - 1)];
		end
	endtask

	// response side: random stalls, one long hold-off in the pressure phase
	always @(posedge clk) begin
		if (pressure_on && hold_count < HOLD_CYCLES) begin
			m_axis_tready <= 1'b0;
			hold_count    <= hold_count + 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each response with the oldest one due
	always @(posedge clk) begin
		heap_resp_t due;
		if (m_axis_tvalid && m_axis_tready) begin
			if (resp_due.size() == 0) begin
				$error("unexpected response: status %0d offset %0d", m_axis_tuser,
					m_axis_tdata[OFF_W-1:0]);
				errors++;
			end else begin
				due = resp_due.pop_front();
				if (m_axis_tuser !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, m_axis_tuser);
					errors++;
				end
				if (m_axis_tdata[OFF_W-1:0] !== due.offset) begin
					$error("alloc_offset: expected %0d, got %0d", due.offset,
						m_axis_tdata[OFF_W-1:0]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [OPCODE_W-1:0] op;
		logic [REQ_W-1:0]    size;
		logic [OFF_W-1:0]    doff;
		heap_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed corner cases
		foreach (DIRECTED[i]) begin
			send_request(DIRECTED[i].op, DIRECTED[i].size, DIRECTED[i].doff, DIRECTED[i].fixed,
				DIRECTED[i].resp);
		end

		// random traffic under each idling pattern
		for (int p = 0; p < N_PHASES; p++) begin
			send_idle_pct  = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			pressure_on    = (p == PRESSURE_PH);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick_request(op, size, doff);
				send_request(op, size, doff, 1'b0, '0);
			end
		end
		s_axis_tvalid <= 1'b0;
		recv_stall_pct = 0;

		// drain
		while (resp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
